// ===== rtl/mfa_pkg.sv =====
// Package: types and constants for the Merkle forest append unit.
package mfa_pkg;

    localparam int HashWords = 4;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_BAD_IDX  = 2'd1,
        ST_FULL     = 2'd2,
        ST_RSVD     = 2'd3
    } status_t;

    localparam logic OP_APPEND = 1'b0;
    localparam logic OP_READ   = 1'b1;

    typedef struct packed {
        logic        operation;
        logic [63:0] leaf_word0;
        logic [63:0] leaf_word1;
        logic [63:0] leaf_word2;
        logic [63:0] leaf_word3;
        logic [5:0]  root_index;
    } req_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [63:0] root_word0;
        logic [63:0] root_word1;
        logic [63:0] root_word2;
        logic [63:0] root_word3;
        logic [5:0]  root_level;
        logic [63:0] leaf_total;
    } rsp_t;

    typedef enum logic [3:0] {
        BK_IDLE,
        BK_RD_ADDR,
        BK_RD_WAIT,
        BK_RD_DATA,
        BK_POP_ADDR,
        BK_POP_WAIT,
        BK_POP_DATA,
        BK_HASH,
        BK_HASH_WAIT,
        BK_PUSH,
        BK_ROW_SCAN,
        BK_DONE
    } bk_state_t;

    localparam logic [63:0] IV [8] = '{
        64'h22312194FC2C2CB7, 64'h9F555FA3C84C64C2, 64'h2393B86B6F53B151,
        64'h963877195940EABD, 64'h96283EE2A88EFFE3, 64'hBE5E1E2553863992,
        64'h2B0199FC2C85B8AA, 64'h0EB72DDC81C52CA2
    };

    localparam logic [63:0] RK [80] = '{
        64'h428a2f98d728ae22, 64'h7137449123ef65cd, 64'hb5c0fbcfec4d3b2f, 64'he9b5dba58189dbbc,
        64'h3956c25bf348b538, 64'h59f111f1b605d019, 64'h923f82a4af194f9b, 64'hab1c5ed5da6d8118,
        64'hd807aa98a3030242, 64'h12835b0145706fbe, 64'h243185be4ee4b28c, 64'h550c7dc3d5ffb4e2,
        64'h72be5d74f27b896f, 64'h80deb1fe3b1696b1, 64'h9bdc06a725c71235, 64'hc19bf174cf692694,
        64'he49b69c19ef14ad2, 64'hefbe4786384f25e3, 64'h0fc19dc68b8cd5b5, 64'h240ca1cc77ac9c65,
        64'h2de92c6f592b0275, 64'h4a7484aa6ea6e483, 64'h5cb0a9dcbd41fbd4, 64'h76f988da831153b5,
        64'h983e5152ee66dfab, 64'ha831c66d2db43210, 64'hb00327c898fb213f, 64'hbf597fc7beef0ee4,
        64'hc6e00bf33da88fc2, 64'hd5a79147930aa725, 64'h06ca6351e003826f, 64'h142929670a0e6e70,
        64'h27b70a8546d22ffc, 64'h2e1b21385c26c926, 64'h4d2c6dfc5ac42aed, 64'h53380d139d95b3df,
        64'h650a73548baf63de, 64'h766a0abb3c77b2a8, 64'h81c2c92e47edaee6, 64'h92722c851482353b,
        64'ha2bfe8a14cf10364, 64'ha81a664bbc423001, 64'hc24b8b70d0f89791, 64'hc76c51a30654be30,
        64'hd192e819d6ef5218, 64'hd69906245565a910, 64'hf40e35855771202a, 64'h106aa07032bbd1b8,
        64'h19a4c116b8d2d0c8, 64'h1e376c085141ab53, 64'h2748774cdf8eeb99, 64'h34b0bcb5e19b48a8,
        64'h391c0cb3c5c95a63, 64'h4ed8aa4ae3418acb, 64'h5b9cca4f7763e373, 64'h682e6ff3d6b2b8a3,
        64'h748f82ee5defb2fc, 64'h78a5636f43172f60, 64'h84c87814a1f0ab72, 64'h8cc702081a6439ec,
        64'h90befffa23631e28, 64'ha4506cebde82bde9, 64'hbef9a3f7b2c67915, 64'hc67178f2e372532b,
        64'hca273eceea26619c, 64'hd186b8c721c0c207, 64'heada7dd6cde0eb1e, 64'hf57d4f7fee6ed178,
        64'h06f067aa72176fba, 64'h0a637dc5a2c898a6, 64'h113f9804bef90dae, 64'h1b710b35131c471b,
        64'h28db77f523047d84, 64'h32caab7b40c72493, 64'h3c9ebe0a15c9bebc, 64'h431d67c49c100d4c,
        64'h4cc5d4becb3e42b6, 64'h597f299cfc657e2a, 64'h5fcb6fab3ad6faec, 64'h6c44198c4a475817
    };

    function automatic logic [63:0] rotr(input logic [63:0] x, input int n);
        rotr = (x >> n) | (x << (64 - n));
    endfunction

endpackage

// ===== rtl/mfa_ram.sv =====
// Generic single-port RAM with registered read.
module mfa_ram #(
    parameter int WIDTH = 256,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end
endmodule

// ===== rtl/mfa_sha_core.sv =====
// Iterative SHA-512/256 compression of one padded 128-byte block, one round a cycle.
module mfa_sha_core
    import mfa_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         start,
    input  logic [255:0] left,
    input  logic [255:0] right,
    output logic         done,
    output logic [255:0] digest
);
    logic [63:0] w_reg [16];
    logic [63:0] s_reg [8];
    logic [6:0]  rnd_reg;
    logic        busy_reg;
    logic        done_reg;

    logic [63:0] wt, wnew, t1, t2, e, a, s0, s1;

    always_comb
    begin
        wt   = w_reg[0];
        s0   = rotr(w_reg[1], 1) ^ rotr(w_reg[1], 8) ^ (w_reg[1] >> 7);
        s1   = rotr(w_reg[14], 19) ^ rotr(w_reg[14], 61) ^ (w_reg[14] >> 6);
        wnew = w_reg[0] + s0 + w_reg[9] + s1;
        e    = s_reg[4];
        a    = s_reg[0];
        t1   = s_reg[7] + (rotr(e, 14) ^ rotr(e, 18) ^ rotr(e, 41))
             + ((e & s_reg[5]) ^ (~e & s_reg[6])) + RK[rnd_reg] + wt;
        t2   = (rotr(a, 28) ^ rotr(a, 34) ^ rotr(a, 39))
             + ((a & s_reg[1]) ^ (a & s_reg[2]) ^ (s_reg[1] & s_reg[2]));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            rnd_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                rnd_reg  <= '0;
            end
            else if (busy_reg)
            begin
                if (rnd_reg == 7'd79)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
                else
                begin
                    rnd_reg <= rnd_reg + 7'd1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            for (int i = 0; i < 4; i++)
            begin
                w_reg[i]     <= left[255-64*i -: 64];
                w_reg[i + 4] <= right[255-64*i -: 64];
            end
            w_reg[8] <= 64'h8000000000000000;
            for (int i = 9; i < 15; i++)
            begin
                w_reg[i] <= '0;
            end
            w_reg[15] <= 64'd512;
            for (int i = 0; i < 8; i++)
            begin
                s_reg[i] <= IV[i];
            end
        end
        else if (busy_reg)
        begin
            for (int i = 0; i < 15; i++)
            begin
                w_reg[i] <= w_reg[i + 1];
            end
            w_reg[15] <= wnew;
            s_reg[7] <= s_reg[6];
            s_reg[6] <= s_reg[5];
            s_reg[5] <= s_reg[4];
            s_reg[4] <= s_reg[3] + t1;
            s_reg[3] <= s_reg[2];
            s_reg[2] <= s_reg[1];
            s_reg[1] <= s_reg[0];
            s_reg[0] <= t1 + t2;
        end
    end

    assign done   = done_reg;
    assign digest = {IV[0] + s_reg[0], IV[1] + s_reg[1], IV[2] + s_reg[2], IV[3] + s_reg[3]};
endmodule

// ===== rtl/mfa_front.sv =====
// Front end: takes requests and holds them in a two-entry queue for the back end.
module mfa_front
    import mfa_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    output logic full,
    input  req_t req,
    input  logic take,
    output logic avail,
    output req_t head
);
    req_t       q_reg [2];
    logic       rd_reg, wr_reg;
    logic [1:0] cnt_reg;

    assign full  = cnt_reg == 2'd2;
    assign avail = cnt_reg != 2'd0;
    assign head  = q_reg[rd_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_reg  <= 1'b0;
            wr_reg  <= 1'b0;
            cnt_reg <= '0;
        end
        else
        begin
            if (push && !full)
            begin
                wr_reg <= ~wr_reg;
            end
            if (take && avail)
            begin
                rd_reg <= ~rd_reg;
            end
            cnt_reg <= cnt_reg + {1'b0, push && !full} - {1'b0, take && avail};
        end
    end

    always_ff @(posedge clk)
    begin
        if (push && !full)
        begin
            q_reg[wr_reg] <= req;
        end
    end
endmodule

// ===== rtl/mfa_back.sv =====
// Back end: carries out append and read requests on the root stack.
module mfa_back
    import mfa_pkg::*;
#(
    parameter int ROOT_SLOTS = 64
) (
    input  logic clk,
    input  logic rst_n,
    input  logic avail,
    input  req_t head,
    output logic take,
    output logic empty,
    input  logic pop,
    output rsp_t rsp
);
    localparam int AW = $clog2(ROOT_SLOTS);
    localparam int DW = $clog2(ROOT_SLOTS + 1);

    bk_state_t   st_reg, st_next;
    logic [63:0] cnt_reg;
    logic [DW-1:0] dep_reg;
    logic [255:0] cur_reg;
    logic [5:0]  row_reg;
    logic [6:0]  scan_reg;
    logic [5:0]  seen_reg;
    logic        op_reg;
    logic [5:0]  idx_reg;
    logic [1:0]  stat_reg;
    rsp_t        out_reg;
    logic        outv_reg;

    logic          ram_we;
    logic [AW-1:0] ram_addr;
    logic [255:0]  ram_rdata;
    logic          sha_start, sha_done;
    logic [255:0]  sha_dig;
    logic [63:0]   cnt_inc;
    logic [6:0]    ones_next;
    logic          rsp_free;

    mfa_ram #(.WIDTH(256), .DEPTH(ROOT_SLOTS)) u_ram (
        .clk(clk), .we(ram_we), .addr(ram_addr), .wdata(cur_reg), .rdata(ram_rdata)
    );

    mfa_sha_core u_sha (
        .clk(clk), .rst_n(rst_n), .start(sha_start), .left(ram_rdata), .right(cur_reg),
        .done(sha_done), .digest(sha_dig)
    );

    assign cnt_inc = cnt_reg + 64'd1;
    // Popcount of count+1 equals popcount(count) minus trailing ones plus one; root
    // count equals stack depth, so full when trailing ones is zero and depth is max.
    assign ones_next = 7'(dep_reg) + 7'd1;
    assign empty = !outv_reg;
    assign rsp   = out_reg;
    // Response register can take a new response this cycle.
    assign rsp_free = !outv_reg || pop;

    always_comb
    begin
        st_next   = st_reg;
        take      = 1'b0;
        ram_we    = 1'b0;
        // Reads keep the chosen entry addressed until the response is loaded.
        ram_addr  = (op_reg == OP_READ) ? AW'(idx_reg) : AW'(dep_reg);
        sha_start = 1'b0;
        unique case (st_reg)
            BK_IDLE:
            begin
                if (avail)
                begin
                    take    = 1'b1;
                    st_next = (head.operation == OP_READ) ? BK_RD_ADDR : BK_POP_ADDR;
                end
            end
            BK_RD_ADDR:
            begin
                ram_addr = AW'(idx_reg);
                st_next  = BK_RD_WAIT;
            end
            BK_RD_WAIT:   st_next = BK_ROW_SCAN;
            BK_ROW_SCAN:  if (scan_reg[6]) st_next = BK_DONE;
            BK_POP_ADDR:
            begin
                ram_addr = AW'(dep_reg - DW'(1));
                if (stat_reg != ST_OK)
                begin
                    st_next = BK_DONE;
                end
                else if (row_reg == 6'd63 && cnt_reg[63] || !cnt_reg[row_reg])
                begin
                    st_next = BK_PUSH;
                end
                else
                begin
                    st_next = BK_POP_WAIT;
                end
            end
            BK_POP_WAIT:
            begin
                ram_addr = AW'(dep_reg);
                st_next  = BK_HASH;
            end
            BK_HASH:
            begin
                sha_start = 1'b1;
                st_next   = BK_HASH_WAIT;
            end
            BK_HASH_WAIT: if (sha_done) st_next = BK_POP_ADDR;
            BK_PUSH:
            begin
                ram_we  = 1'b1;
                st_next = BK_DONE;
            end
            BK_DONE:      if (rsp_free) st_next = BK_IDLE;
            default:      st_next = BK_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg   <= BK_IDLE;
            cnt_reg  <= '0;
            dep_reg  <= '0;
            outv_reg <= 1'b0;
        end
        else
        begin
            st_reg <= st_next;
            if (st_reg == BK_DONE && rsp_free)
            begin
                outv_reg <= 1'b1;
            end
            else if (pop && outv_reg)
            begin
                outv_reg <= 1'b0;
            end
            case (st_reg)
                BK_POP_ADDR:
                begin
                    if (stat_reg == ST_OK && st_next == BK_POP_WAIT)
                    begin
                        dep_reg <= dep_reg - DW'(1);
                    end
                end
                BK_PUSH:
                begin
                    dep_reg <= dep_reg + DW'(1);
                    cnt_reg <= cnt_inc;
                end
                default:  ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        case (st_reg)
            BK_IDLE:
            begin
                op_reg   <= head.operation;
                idx_reg  <= head.root_index;
                cur_reg  <= {head.leaf_word0, head.leaf_word1, head.leaf_word2,
                             head.leaf_word3};
                row_reg  <= '0;
                scan_reg <= 7'd63;
                seen_reg <= '0;
                if (head.operation == OP_READ)
                begin
                    stat_reg <= ({1'b0, head.root_index} >= 7'(dep_reg)) ? ST_BAD_IDX : ST_OK;
                end
                else
                begin
                    stat_reg <= (&cnt_reg || (!cnt_reg[0] && ones_next > 7'(ROOT_SLOTS)))
                              ? ST_FULL : ST_OK;
                end
            end
            BK_ROW_SCAN:
            begin
                if (!scan_reg[6])
                begin
                    if (cnt_reg[scan_reg[5:0]])
                    begin
                        if (seen_reg == idx_reg)
                        begin
                            row_reg <= scan_reg[5:0];
                        end
                        seen_reg <= seen_reg + 6'd1;
                    end
                    scan_reg <= scan_reg - 7'd1;
                end
            end
            BK_HASH_WAIT:
            begin
                if (sha_done)
                begin
                    cur_reg <= sha_dig;
                    row_reg <= row_reg + 6'd1;
                end
            end
            default: ;
        endcase
        if (st_reg == BK_DONE && rsp_free)
        begin
            out_reg.status     <= stat_reg;
            out_reg.leaf_total <= cnt_reg;
            if (stat_reg != ST_OK)
            begin
                out_reg.root_word0 <= '0;
                out_reg.root_word1 <= '0;
                out_reg.root_word2 <= '0;
                out_reg.root_word3 <= '0;
                out_reg.root_level <= '0;
            end
            else
            begin
                out_reg.root_word0 <= op_reg ? ram_rdata[255:192] : cur_reg[255:192];
                out_reg.root_word1 <= op_reg ? ram_rdata[191:128] : cur_reg[191:128];
                out_reg.root_word2 <= op_reg ? ram_rdata[127:64]  : cur_reg[127:64];
                out_reg.root_word3 <= op_reg ? ram_rdata[63:0]    : cur_reg[63:0];
                out_reg.root_level <= row_reg;
            end
        end
    end
endmodule

// ===== rtl/merkle_forest_append_sha512_unit.sv =====
// Merkle forest append unit over SHA-512/256, top level.
// From acceptance with the back end idle, a read passes an address state, a wait state and
// a 64-step row scan; an append merges one popped root per trailing one of the count, each
// merge running the SHA core at one round per cycle, then pushes the result. The back end
// takes one request at a time; a response left unpopped holds it in its last state.
// Reset: rst_n clears count, stack depth, queues; stored roots are left unset.
module merkle_forest_append_sha512_unit
    import mfa_pkg::*;
#(
    parameter int ROOT_SLOTS = 64
) (
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    output logic full,
    input  req_t req,
    output logic empty,
    input  logic pop,
    output rsp_t rsp
);
    // Request queue between front and back so each side can stall on its own.
    logic avail, take;
    req_t head;

    mfa_front u_front (
        .clk(clk), .rst_n(rst_n), .push(push), .full(full), .req(req),
        .take(take), .avail(avail), .head(head)
    );

    // The back end pops roots, hashes, pushes the result or reads a root, and holds one response.
    mfa_back #(.ROOT_SLOTS(ROOT_SLOTS)) u_back (
        .clk(clk), .rst_n(rst_n), .avail(avail), .head(head), .take(take),
        .empty(empty), .pop(pop), .rsp(rsp)
    );
endmodule

// ===== rtl/mfa_checker.sv =====
// Port-level checker for the Merkle forest append unit, with its bind.
module mfa_checker
    import mfa_pkg::*;
(
    input logic clk,
    input logic rst_n,
    input logic empty,
    input logic pop,
    input rsp_t rsp
);
    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> rsp.status != ST_RSVD) else $error("reserved status");
    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && rsp.status != ST_OK) |-> (rsp.root_word0 == '0 && rsp.root_level == '0))
        else $error("error response not zeroed");
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(rsp))) else $error("response dropped");
    a_total_mono: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && pop) |=> (empty || rsp.leaf_total >= $past(rsp.leaf_total)))
        else $error("leaf total went down");
endmodule

bind merkle_forest_append_sha512_unit mfa_checker u_chk (
    .clk(clk), .rst_n(rst_n), .empty(empty), .pop(pop), .rsp(rsp)
);
